@@ src/dpbm_pkg.sv @@
// Shared types and constants of the decoded picture buffer manager.
// No dependencies; used by the controller, the datapath and the top level.
package dpbm_pkg;

    localparam int DPB_SLOTS = 32;
    localparam int SLOT_W    = (DPB_SLOTS > 1) ? $clog2(DPB_SLOTS) : 1;
    localparam int CUR_W     = SLOT_W + 1;
    localparam int CNT_W     = $clog2(DPB_SLOTS + 1);

    localparam logic signed [31:0] POC_MAX = 32'sh7fffffff;

    // slot marks
    localparam logic [3:0] MK_OUT   = 4'b0001;
    localparam logic [3:0] MK_SHORT = 4'b0010;
    localparam logic [3:0] MK_LONG  = 4'b0100;
    localparam logic [3:0] MK_BUMP  = 4'b1000;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CURRENT = 2'd3;

    // last short-term reference class (delta relative to current POC)
    localparam logic [2:0] CLS_ST_FOLLOW = 3'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REORDER  = 2'd0;
    localparam logic [1:0] CFG_MAX_PICS = 2'd1;
    localparam logic [1:0] CFG_POC_LSB  = 2'd2;

    typedef enum logic [2:0] {
        MODE_NEW_SEQ  = 3'd0,
        MODE_NEW_PIC  = 3'd1,
        MODE_BEGIN    = 3'd2,
        MODE_ADD_REF  = 3'd3,
        MODE_RELEASE  = 3'd4,
        MODE_OUTPUT   = 3'd5,
        MODE_BUMP     = 3'd6
    } t_mode;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_NEW_SEQ,
        OP_BEGIN_MARK,
        OP_RELEASE,
        OP_SCAN_DUP,
        OP_ALLOC_PIC,
        OP_SCAN_MASK,
        OP_SCAN_EXACT,
        OP_REF_COMMIT,
        OP_SCAN_DROP,
        OP_SCAN_MIN,
        OP_OUT_COMMIT,
        OP_OUT_ADVANCE,
        OP_SCAN_FILL,
        OP_SCAN_BMIN,
        OP_SCAN_BMARK,
        OP_LOAD_RESULT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUP_SCAN,
        S_PIC_COMMIT,
        S_MASK_SCAN,
        S_EXACT_SCAN,
        S_REF_COMMIT,
        S_DROP_SCAN,
        S_MIN_SCAN,
        S_OUT_DECIDE,
        S_FILL_SCAN,
        S_FILL_CHECK,
        S_BMIN_SCAN,
        S_BMARK_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  drop;
        logic  last;      // scan index on final slot
        logic  hold;      // output held back by reorder limit
        logic  found;
        logic  seq_eq;    // output sequence caught up with decode sequence
        logic  fill_ge;
        logic  out_free;  // output register can take a result
    } t_dp_stat;

endpackage

@@ src/dpbm_ctrl.sv @@
// Controller of the decoded picture buffer manager: event sequencing FSM.
// Depends on dpbm_pkg; drives dpbm_datapath through command/status structs.
module dpbm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dpbm_pkg::t_dp_stat i_stat,
    output dpbm_pkg::t_dp_cmd  o_cmd
);

    dpbm_pkg::t_state r_state;
    dpbm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpbm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == dpbm_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = dpbm_pkg::OP_NONE;
        case (r_state)
            dpbm_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = dpbm_pkg::OP_LATCH;
                    n_state  = dpbm_pkg::S_DISPATCH;
                end
            end
            dpbm_pkg::S_DISPATCH: begin
                case (i_stat.mode)
                    dpbm_pkg::MODE_NEW_SEQ: begin
                        o_cmd.op = dpbm_pkg::OP_NEW_SEQ;
                        n_state  = dpbm_pkg::S_RESULT;
                    end
                    dpbm_pkg::MODE_NEW_PIC: n_state = dpbm_pkg::S_DUP_SCAN;
                    dpbm_pkg::MODE_BEGIN: begin
                        o_cmd.op = dpbm_pkg::OP_BEGIN_MARK;
                        n_state  = dpbm_pkg::S_RESULT;
                    end
                    dpbm_pkg::MODE_ADD_REF: n_state = dpbm_pkg::S_MASK_SCAN;
                    dpbm_pkg::MODE_RELEASE: begin
                        o_cmd.op = dpbm_pkg::OP_RELEASE;
                        n_state  = dpbm_pkg::S_RESULT;
                    end
                    dpbm_pkg::MODE_OUTPUT:
                        n_state = i_stat.drop ? dpbm_pkg::S_DROP_SCAN : dpbm_pkg::S_MIN_SCAN;
                    dpbm_pkg::MODE_BUMP: n_state = dpbm_pkg::S_FILL_SCAN;
                    default: n_state = dpbm_pkg::S_RESULT;
                endcase
            end
            dpbm_pkg::S_DUP_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_DUP;
                if (i_stat.last) n_state = dpbm_pkg::S_PIC_COMMIT;
            end
            dpbm_pkg::S_PIC_COMMIT: begin
                o_cmd.op = dpbm_pkg::OP_ALLOC_PIC;
                n_state  = dpbm_pkg::S_RESULT;
            end
            dpbm_pkg::S_MASK_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_MASK;
                if (i_stat.last) n_state = dpbm_pkg::S_EXACT_SCAN;
            end
            dpbm_pkg::S_EXACT_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_EXACT;
                if (i_stat.last) n_state = dpbm_pkg::S_REF_COMMIT;
            end
            dpbm_pkg::S_REF_COMMIT: begin
                o_cmd.op = dpbm_pkg::OP_REF_COMMIT;
                n_state  = dpbm_pkg::S_RESULT;
            end
            dpbm_pkg::S_DROP_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_DROP;
                if (i_stat.last) n_state = dpbm_pkg::S_MIN_SCAN;
            end
            dpbm_pkg::S_MIN_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_MIN;
                if (i_stat.last) n_state = dpbm_pkg::S_OUT_DECIDE;
            end
            dpbm_pkg::S_OUT_DECIDE: begin
                if (i_stat.hold) begin
                    n_state = dpbm_pkg::S_RESULT;
                end else if (i_stat.found) begin
                    o_cmd.op = dpbm_pkg::OP_OUT_COMMIT;
                    n_state  = dpbm_pkg::S_RESULT;
                end else if (i_stat.seq_eq) begin
                    n_state = dpbm_pkg::S_RESULT;
                end else begin
                    // nothing left in this sequence: move on and rescan
                    o_cmd.op = dpbm_pkg::OP_OUT_ADVANCE;
                    n_state  = i_stat.drop ? dpbm_pkg::S_DROP_SCAN : dpbm_pkg::S_MIN_SCAN;
                end
            end
            dpbm_pkg::S_FILL_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_FILL;
                if (i_stat.last) n_state = dpbm_pkg::S_FILL_CHECK;
            end
            dpbm_pkg::S_FILL_CHECK: begin
                n_state = i_stat.fill_ge ? dpbm_pkg::S_BMIN_SCAN : dpbm_pkg::S_RESULT;
            end
            dpbm_pkg::S_BMIN_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_BMIN;
                if (i_stat.last) n_state = dpbm_pkg::S_BMARK_SCAN;
            end
            dpbm_pkg::S_BMARK_SCAN: begin
                o_cmd.op = dpbm_pkg::OP_SCAN_BMARK;
                if (i_stat.last) n_state = dpbm_pkg::S_RESULT;
            end
            dpbm_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = dpbm_pkg::OP_LOAD_RESULT;
                    n_state  = dpbm_pkg::S_IDLE;
                end
            end
            default: n_state = dpbm_pkg::S_IDLE;
        endcase
    end

endmodule

@@ src/dpbm_datapath.sv @@
// Datapath of the decoded picture buffer manager: slot store, scan unit,
// configuration and output registers. Depends on dpbm_pkg.
module dpbm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpbm_pkg::t_dp_cmd   i_cmd,
    output dpbm_pkg::t_dp_stat  o_stat,
    input  logic [2:0]          i_mode,
    input  logic signed [31:0]  i_poc_value,
    input  logic                i_show_flag,
    input  logic [2:0]          i_ref_class,
    input  logic                i_flush,
    input  logic                i_drop_prior,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [5:0]          i_cfg_data,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic                o_has_picture,
    output logic [4:0]          o_slot,
    output logic signed [31:0]  o_picture_poc,
    output logic [2:0]          o_list_class
);

    localparam int SW = dpbm_pkg::SLOT_W;

    // slot store
    logic [dpbm_pkg::DPB_SLOTS-1:0] r_valid;
    logic [3:0]  r_marks [dpbm_pkg::DPB_SLOTS];
    logic [31:0] r_poc   [dpbm_pkg::DPB_SLOTS];
    logic [7:0]  r_seq   [dpbm_pkg::DPB_SLOTS];

    logic [7:0]                r_dec_seq;
    logic [7:0]                r_out_seq;
    logic [dpbm_pkg::CUR_W-1:0] r_cur_slot;
    logic [31:0]               r_cur_poc;

    logic [4:0] r_reorder;
    logic [5:0] r_max_pics;
    logic [4:0] r_poc_lsb;

    // scan state
    logic [SW-1:0]              r_idx;
    logic                       r_found;
    logic                       r_free_found;
    logic [dpbm_pkg::CNT_W-1:0] r_count;
    logic [SW-1:0]              r_fidx;
    logic [SW-1:0]              r_free_idx;
    logic [31:0]                r_fpoc;
    logic [3:0]                 r_fmarks;
    logic signed [31:0]         r_min;

    // latched item
    dpbm_pkg::t_mode r_mode;
    logic [31:0]     r_pv;
    logic [31:0]     r_target;
    logic [31:0]     r_mask;
    logic            r_show;
    logic [2:0]      r_cls;
    logic            r_flush;
    logic            r_drop;

    // working result and output register
    logic [1:0]  r_res_status;
    logic        r_res_has;
    logic [4:0]  r_res_slot;
    logic [31:0] r_res_poc;
    logic [2:0]  r_res_cls;
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic        r_o_has;
    logic [4:0]  r_o_slot;
    logic [31:0] r_o_poc;
    logic [2:0]  r_o_cls;

    logic        w_v;
    logic [3:0]  w_m;
    logic [31:0] w_p;
    logic [7:0]  w_s;
    logic        w_in_dec;
    logic        w_in_out;
    logic        w_hit_dup;
    logic        w_hit_mask;
    logic        w_hit_exact;
    logic        w_hit_drop;
    logic        w_hit_min;
    logic        w_hit_fill;
    logic        w_hit_bmin;
    logic        w_hit_bmark;
    logic        w_last;
    logic        w_scan;
    logic        w_ref_cur;
    logic [SW-1:0] w_ref_idx;
    logic [3:0]  w_ref_base;
    logic [3:0]  w_ref_mark;
    logic [3:0]  w_drop_m;
    logic [3:0]  w_commit_m;

    assign w_v = r_valid[r_idx];
    assign w_m = r_marks[r_idx];
    assign w_p = r_poc[r_idx];
    assign w_s = r_seq[r_idx];

    assign w_in_dec    = w_v && (w_s == r_dec_seq);
    assign w_in_out    = w_v && (w_s == r_out_seq);
    assign w_hit_dup   = w_in_dec && (w_p == r_pv);
    assign w_hit_mask  = w_in_dec && ((w_p & r_mask) == r_target);
    assign w_hit_exact = w_in_dec && (w_p == r_target);
    assign w_hit_drop  = w_in_out && ((w_m & dpbm_pkg::MK_BUMP) == 4'd0) && (w_p != r_cur_poc);
    assign w_hit_min   = w_in_out && ((w_m & dpbm_pkg::MK_OUT) != 4'd0);
    assign w_hit_fill  = w_in_out && (w_m != 4'd0) && (w_p != r_cur_poc);
    assign w_hit_bmin  = w_in_out && (w_m == dpbm_pkg::MK_OUT) && (w_p != r_cur_poc)
                         && ($signed(w_p) < r_min);
    assign w_hit_bmark = w_in_out && ((w_m & dpbm_pkg::MK_OUT) != 4'd0)
                         && ($signed(w_p) <= r_min);

    assign w_drop_m   = w_m & ~dpbm_pkg::MK_OUT;
    assign w_commit_m = r_fmarks & ~(dpbm_pkg::MK_OUT | dpbm_pkg::MK_BUMP);

    assign w_ref_cur  = r_found && ({1'b0, r_fidx} == r_cur_slot);
    assign w_ref_idx  = r_found ? r_fidx : r_free_idx;
    assign w_ref_base = r_found ? r_fmarks : 4'd0;
    assign w_ref_mark = (w_ref_base & ~(dpbm_pkg::MK_SHORT | dpbm_pkg::MK_LONG))
                        | ((r_cls <= dpbm_pkg::CLS_ST_FOLLOW) ? dpbm_pkg::MK_SHORT
                                                               : dpbm_pkg::MK_LONG);

    assign w_last = (r_idx == SW'(dpbm_pkg::DPB_SLOTS - 1));
    assign w_scan = (i_cmd.op == dpbm_pkg::OP_SCAN_DUP)   || (i_cmd.op == dpbm_pkg::OP_SCAN_MASK)
                 || (i_cmd.op == dpbm_pkg::OP_SCAN_EXACT) || (i_cmd.op == dpbm_pkg::OP_SCAN_DROP)
                 || (i_cmd.op == dpbm_pkg::OP_SCAN_MIN)   || (i_cmd.op == dpbm_pkg::OP_SCAN_FILL)
                 || (i_cmd.op == dpbm_pkg::OP_SCAN_BMIN)  || (i_cmd.op == dpbm_pkg::OP_SCAN_BMARK);

    assign o_stat.mode     = r_mode;
    assign o_stat.drop     = r_drop;
    assign o_stat.last     = w_last;
    assign o_stat.hold     = !r_flush && (r_out_seq == r_dec_seq)
                             && (int'(r_count) <= int'(r_reorder));
    assign o_stat.found    = r_found;
    assign o_stat.seq_eq   = (r_out_seq == r_dec_seq);
    assign o_stat.fill_ge  = (int'(r_count) >= int'(r_max_pics));
    assign o_stat.out_free = !r_o_valid || i_ready;

    // control state and slot marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            for (int i = 0; i < dpbm_pkg::DPB_SLOTS; i++) r_marks[i] <= 4'd0;
            r_dec_seq    <= 8'd0;
            r_out_seq    <= 8'd0;
            r_cur_slot   <= dpbm_pkg::CUR_W'(dpbm_pkg::DPB_SLOTS);
            r_cur_poc    <= 32'd0;
            r_reorder    <= 5'd0;
            r_max_pics   <= 6'd16;
            r_poc_lsb    <= 5'd8;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dpbm_pkg::CFG_REORDER:  r_reorder  <= i_cfg_data[4:0];
                    dpbm_pkg::CFG_MAX_PICS: r_max_pics <= i_cfg_data;
                    dpbm_pkg::CFG_POC_LSB:  r_poc_lsb  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == dpbm_pkg::OP_LOAD_RESULT) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_scan) r_idx <= w_last ? '0 : r_idx + SW'(1);

            case (i_cmd.op)
                dpbm_pkg::OP_LATCH: begin
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    r_count      <= '0;
                end
                dpbm_pkg::OP_NEW_SEQ: begin
                    for (int i = 0; i < dpbm_pkg::DPB_SLOTS; i++) begin
                        if (r_valid[i]) begin
                            r_marks[i] <= r_marks[i] & ~(dpbm_pkg::MK_SHORT | dpbm_pkg::MK_LONG);
                            if ((r_marks[i] & ~(dpbm_pkg::MK_SHORT | dpbm_pkg::MK_LONG)) == 4'd0)
                                r_valid[i] <= 1'b0;
                        end
                    end
                    r_cur_slot <= dpbm_pkg::CUR_W'(dpbm_pkg::DPB_SLOTS);
                    r_dec_seq  <= r_dec_seq + 8'd1;
                end
                dpbm_pkg::OP_BEGIN_MARK: begin
                    for (int i = 0; i < dpbm_pkg::DPB_SLOTS; i++) begin
                        if (dpbm_pkg::CUR_W'(i) != r_cur_slot)
                            r_marks[i] <= r_marks[i] & ~(dpbm_pkg::MK_SHORT | dpbm_pkg::MK_LONG);
                    end
                end
                dpbm_pkg::OP_RELEASE: begin
                    for (int i = 0; i < dpbm_pkg::DPB_SLOTS; i++) begin
                        if (r_valid[i] && (r_marks[i] == 4'd0)) r_valid[i] <= 1'b0;
                    end
                end
                dpbm_pkg::OP_SCAN_DUP: begin
                    if (w_hit_dup) r_found <= 1'b1;
                    if (!w_v) r_free_found <= 1'b1;
                end
                dpbm_pkg::OP_ALLOC_PIC: begin
                    if (!r_found && r_free_found) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_marks[r_free_idx] <= dpbm_pkg::MK_SHORT | {3'd0, r_show};
                        r_cur_slot          <= {1'b0, r_free_idx};
                        r_cur_poc           <= r_pv;
                    end
                end
                dpbm_pkg::OP_SCAN_MASK: begin
                    if (w_hit_mask) r_found <= 1'b1;
                    if (!w_v) r_free_found <= 1'b1;
                end
                dpbm_pkg::OP_SCAN_EXACT: begin
                    if (w_hit_exact) r_found <= 1'b1;
                end
                dpbm_pkg::OP_REF_COMMIT: begin
                    if (!w_ref_cur && (r_found || r_free_found)) begin
                        r_marks[w_ref_idx] <= w_ref_mark;
                        r_valid[w_ref_idx] <= 1'b1;
                    end
                end
                dpbm_pkg::OP_SCAN_DROP: begin
                    if (w_hit_drop) begin
                        r_marks[r_idx] <= w_drop_m;
                        if (w_drop_m == 4'd0) r_valid[r_idx] <= 1'b0;
                    end
                end
                dpbm_pkg::OP_SCAN_MIN: begin
                    if (w_hit_min) begin
                        r_count <= r_count + dpbm_pkg::CNT_W'(1);
                        r_found <= 1'b1;
                    end
                end
                dpbm_pkg::OP_OUT_COMMIT: begin
                    r_marks[r_fidx] <= w_commit_m;
                    if (w_commit_m == 4'd0) r_valid[r_fidx] <= 1'b0;
                end
                dpbm_pkg::OP_OUT_ADVANCE: begin
                    r_out_seq <= r_out_seq + 8'd1;
                    r_found   <= 1'b0;
                    r_count   <= '0;
                end
                dpbm_pkg::OP_SCAN_FILL: begin
                    if (w_hit_fill) r_count <= r_count + dpbm_pkg::CNT_W'(1);
                end
                dpbm_pkg::OP_SCAN_BMARK: begin
                    if (w_hit_bmark) r_marks[r_idx] <= w_m | dpbm_pkg::MK_BUMP;
                end
                default: ;
            endcase
        end
    end

    // payload: slot POC/sequence, latched item, scan captures, results
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dpbm_pkg::OP_LATCH: begin
                r_mode       <= dpbm_pkg::t_mode'(i_mode);
                r_pv         <= i_poc_value;
                r_target     <= (i_ref_class <= dpbm_pkg::CLS_ST_FOLLOW)
                                ? r_cur_poc + i_poc_value : i_poc_value;
                r_mask       <= (32'd1 << r_poc_lsb) - 32'd1;
                r_show       <= i_show_flag;
                r_cls        <= i_ref_class;
                r_flush      <= i_flush;
                r_drop       <= i_drop_prior;
                r_min        <= dpbm_pkg::POC_MAX;
                r_res_status <= dpbm_pkg::ST_OK;
                r_res_has    <= 1'b0;
                r_res_slot   <= 5'd0;
                r_res_poc    <= 32'd0;
                r_res_cls    <= (i_mode == dpbm_pkg::MODE_ADD_REF) ? i_ref_class : 3'd0;
            end
            dpbm_pkg::OP_SCAN_DUP: begin
                if (!w_v && !r_free_found) r_free_idx <= r_idx;
            end
            dpbm_pkg::OP_ALLOC_PIC: begin
                if (r_found) begin
                    r_res_status <= dpbm_pkg::ST_DUP;
                end else if (!r_free_found) begin
                    r_res_status <= dpbm_pkg::ST_FULL;
                end else begin
                    r_poc[r_free_idx] <= r_pv;
                    r_seq[r_free_idx] <= r_dec_seq;
                    r_res_has         <= 1'b1;
                    r_res_slot        <= 5'(r_free_idx);
                    r_res_poc         <= r_pv;
                end
            end
            dpbm_pkg::OP_SCAN_MASK: begin
                if (!w_v && !r_free_found) r_free_idx <= r_idx;
                if (w_hit_mask && !r_found) begin
                    r_fidx   <= r_idx;
                    r_fpoc   <= w_p;
                    r_fmarks <= w_m;
                end
            end
            dpbm_pkg::OP_SCAN_EXACT: begin
                if (w_hit_exact && !r_found) begin
                    r_fidx   <= r_idx;
                    r_fpoc   <= w_p;
                    r_fmarks <= w_m;
                end
            end
            dpbm_pkg::OP_REF_COMMIT: begin
                if (w_ref_cur) begin
                    r_res_status <= dpbm_pkg::ST_CURRENT;
                end else if (!r_found && !r_free_found) begin
                    r_res_status <= dpbm_pkg::ST_FULL;
                end else begin
                    if (!r_found) begin
                        r_poc[r_free_idx] <= r_target;
                        r_seq[r_free_idx] <= r_dec_seq;
                    end
                    r_res_has  <= 1'b1;
                    r_res_slot <= 5'(w_ref_idx);
                    r_res_poc  <= r_found ? r_fpoc : r_target;
                end
            end
            dpbm_pkg::OP_SCAN_MIN: begin
                if (w_hit_min && (!r_found || ($signed(w_p) < r_min))) begin
                    r_min    <= $signed(w_p);
                    r_fidx   <= r_idx;
                    r_fmarks <= w_m;
                end
            end
            dpbm_pkg::OP_OUT_COMMIT: begin
                r_res_has  <= 1'b1;
                r_res_slot <= 5'(r_fidx);
                r_res_poc  <= r_min;
            end
            dpbm_pkg::OP_SCAN_BMIN: begin
                if (w_hit_bmin) r_min <= $signed(w_p);
            end
            dpbm_pkg::OP_LOAD_RESULT: begin
                r_o_status <= r_res_status;
                r_o_has    <= r_res_has;
                r_o_slot   <= r_res_slot;
                r_o_poc    <= r_res_poc;
                r_o_cls    <= r_res_cls;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_has_picture = r_o_has;
    assign o_slot        = r_o_slot;
    assign o_picture_poc = r_o_poc;
    assign o_list_class  = r_o_cls;

endmodule

@@ src/decoded_picture_buffer_manager_top.sv @@
// Decoded picture buffer manager, top level: controller plus datapath.
// Depends on dpbm_pkg, dpbm_ctrl and dpbm_datapath.
//
// One event per input transfer, one result transfer per event. The slot
// store is walked one slot a cycle by a single scan unit. A new picture
// takes one pass over the slots, add reference two, bump one or three, and
// new sequence, begin marking, release and unused modes none, before the
// result is committed and loaded. An output request makes one or two passes
// per sequence examined, and may walk forward through up to 256 sequence
// tags. The next event is accepted as soon as the result has moved into
// the output register, even if it has not yet been taken.
module decoded_picture_buffer_manager_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_poc_value,
    input  logic               i_show_flag,
    input  logic [2:0]         i_ref_class,
    input  logic               i_flush,
    input  logic               i_drop_prior,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic               o_has_picture,
    output logic [4:0]         o_slot,
    output logic signed [31:0] o_picture_poc,
    output logic [2:0]         o_list_class,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [5:0]         i_cfg_data
);

    dpbm_pkg::t_dp_cmd  w_cmd;
    dpbm_pkg::t_dp_stat w_stat;

    dpbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    dpbm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_mode),
        .i_poc_value   (i_poc_value),
        .i_show_flag   (i_show_flag),
        .i_ref_class   (i_ref_class),
        .i_flush       (i_flush),
        .i_drop_prior  (i_drop_prior),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_has_picture (o_has_picture),
        .o_slot        (o_slot),
        .o_picture_poc (o_picture_poc),
        .o_list_class  (o_list_class)
    );

`ifndef SYNTHESIS
    // a result is only loaded when it cannot overwrite a pending transfer
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == dpbm_pkg::OP_LOAD_RESULT) |-> w_stat.out_free)
        else $error("result loaded over pending output");

    a_busy_after_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == dpbm_pkg::OP_LATCH) |=> !o_ready)
        else $error("input ready while event in progress");

    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != dpbm_pkg::ST_OK)) |-> !o_has_picture)
        else $error("failed event reports a slot");
`endif

endmodule
